FILE: design/pba_pkg.sv
package pba_pkg;

   // sizes of the design (register layout fixes them)
   localparam int NUM_PARTITIONS = 4;
   localparam int NUM_BUFFER_IDS = 4;
   localparam int MAX_CHOICES    = 4;

   localparam int LIMIT_REGS = 4;
   localparam int MAP_SLOTS  = 4;
   localparam int PREFS      = 4;
   localparam int SLOT_W     = 11;
   localparam int MAP_W      = 44;
   localparam int PART_W     = 2;
   localparam int COUNT_W    = 3;
   localparam int OCC_W      = 32;
   localparam int BYTES_W    = 16;
   localparam int ID_W       = 8;
   localparam int STATUS_W   = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 44;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 72;
   localparam int RSP_PAD_W  = RSP_DATA_W - PART_W - 2 * OCC_W;

   localparam int ACTIVE_MAX = (NUM_PARTITIONS < LIMIT_REGS) ? NUM_PARTITIONS : LIMIT_REGS;
   localparam int BID_MAX    = (NUM_BUFFER_IDS < MAP_SLOTS) ? NUM_BUFFER_IDS : MAP_SLOTS;
   localparam int CHOICE_MAX = (MAX_CHOICES < PREFS) ? MAX_CHOICES : PREFS;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_PARTITIONS = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT_P0       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT_P1       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT_P2       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT_P3       = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BUFFER_MAP     = 3'd5;

   localparam logic [COUNT_W-1:0] NUM_PARTITIONS_RESET = 3'd4;

   typedef enum logic {
      OP_ENQUEUE = 1'b0,
      OP_DEQUEUE = 1'b1
   } pba_op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK            = 3'd0,
      ST_DROP          = 3'd1,
      ST_BAD_BUFFER    = 3'd2,
      ST_BAD_PARTITION = 3'd3,
      ST_UNDERFLOW     = 3'd4
   } pba_status_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_DECODE,
      SEQ_PROBE,
      SEQ_FINISH
   } pba_state_type;

   typedef struct packed {
      logic [COUNT_W-1:0]                 active;
      logic [LIMIT_REGS-1:0][OCC_W-1:0]   limit;
      logic [MAP_W-1:0]                   map;
   } pba_cfg_type;

   typedef struct packed {
      logic [OCC_W-1:0]   occ;
      logic [OCC_W-1:0]   limit;
      logic [BYTES_W-1:0] bytes;
      logic               sub;
   } pba_alu_req_type;

   typedef struct packed {
      logic [OCC_W-1:0] result;
      logic             ok;
   } pba_alu_rsp_type;

   function automatic logic [SLOT_W-1:0] map_slot(input logic [MAP_W-1:0] map,
                                                  input logic [PART_W-1:0] idx);
      map_slot = map[idx * SLOT_W +: SLOT_W];
   endfunction

   // preference i sits above the 3-bit choice count
   function automatic logic [PART_W-1:0] pref_part(input logic [SLOT_W-1:0] slot,
                                                   input logic [PART_W-1:0] i);
      pref_part = slot[COUNT_W + PART_W * i +: PART_W];
   endfunction

endpackage

FILE: design/partitioned_buffer_admission_unit.sv
// channel | direction | handshake               | payload
// req     | in        | req_tvalid / req_tready | tdata: buffer_id, release_partition,
//         |           |                         |        packet_bytes; tuser: operation
// rsp     | out       | rsp_tvalid / rsp_tready | tdata: chosen_partition, occupancy_after,
//         |           |                         |        partition_limit; tuser: status
// csr     | in        | csr_valid / csr_ready   | csr_index, csr_data
//
// one request steps through accept, decode, then one probe per preference
// examined (up to four) through the shared 33-bit add/compare unit, then a step
// to load the output register. invalid ids skip the probe; a release probes once.
// req_tready is high only while the sequencer idles; a new request is taken while
// a finished result still waits in the output register. reset is synchronous and
// clears the counts, the configuration and all handshake state.
module partitioned_buffer_admission_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [pba_pkg::REQ_DATA_W-1:0]      req_tdata,  // buffer_id, release_partition, packet_bytes
   input  logic                                req_tuser,  // operation
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [pba_pkg::RSP_DATA_W-1:0]      rsp_tdata,  // chosen_partition, occupancy_after, partition_limit, zero pad
   output logic [pba_pkg::STATUS_W-1:0]        rsp_tuser,  // status
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pba_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [pba_pkg::CSR_DATA_W-1:0]      csr_data
);

   pba_pkg::pba_cfg_type     cfg;
   pba_pkg::pba_alu_req_type alu_req;
   pba_pkg::pba_alu_rsp_type alu_rsp;

   assign csr_ready = 1'b1;

   pba_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   pba_alu u_alu (
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   pba_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .alu_req    (alu_req),
      .alu_rsp    (alu_rsp)
   );

   // busy right after taking a request
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while sequencer busy");

   // drops and bad-id rejects carry no partition, count or limit (an underflow does)
   a_fail_payload_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == pba_pkg::ST_DROP || rsp_tuser == pba_pkg::ST_BAD_BUFFER ||
                     rsp_tuser == pba_pkg::ST_BAD_PARTITION) |-> rsp_tdata == '0)
      else $error("nonzero payload on a failed request");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser <= pba_pkg::ST_UNDERFLOW)
      else $error("status code out of range");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("handshake state not cleared by reset");

endmodule

FILE: design/pba_csr.sv
module pba_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   input  logic [pba_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [pba_pkg::CSR_DATA_W-1:0]      csr_data,
   output pba_pkg::pba_cfg_type                cfg
);

   logic [pba_pkg::COUNT_W-1:0]                            num_part_ff, num_part_in;
   logic [pba_pkg::LIMIT_REGS-1:0][pba_pkg::OCC_W-1:0]     limit_ff, limit_in;
   logic [pba_pkg::MAP_W-1:0]                              map_ff, map_in;

   always_comb begin
      num_part_in = num_part_ff;
      limit_in    = limit_ff;
      map_in      = map_ff;
      if (csr_valid) begin
         unique case (csr_index)
            pba_pkg::CSR_NUM_PARTITIONS: num_part_in = csr_data[pba_pkg::COUNT_W-1:0];
            pba_pkg::CSR_LIMIT_P0:       limit_in[0] = csr_data[pba_pkg::OCC_W-1:0];
            pba_pkg::CSR_LIMIT_P1:       limit_in[1] = csr_data[pba_pkg::OCC_W-1:0];
            pba_pkg::CSR_LIMIT_P2:       limit_in[2] = csr_data[pba_pkg::OCC_W-1:0];
            pba_pkg::CSR_LIMIT_P3:       limit_in[3] = csr_data[pba_pkg::OCC_W-1:0];
            pba_pkg::CSR_BUFFER_MAP:     map_in      = csr_data[pba_pkg::MAP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_part_ff <= pba_pkg::NUM_PARTITIONS_RESET;
         limit_ff    <= '0;
         map_ff      <= '0;
      end else begin
         num_part_ff <= num_part_in;
         limit_ff    <= limit_in;
         map_ff      <= map_in;
      end
   end

   // partitions in use, clipped to what the design holds
   assign cfg.active = (num_part_ff > pba_pkg::COUNT_W'(pba_pkg::ACTIVE_MAX))
                       ? pba_pkg::COUNT_W'(pba_pkg::ACTIVE_MAX) : num_part_ff;
   assign cfg.limit  = limit_ff;
   assign cfg.map    = map_ff;

endmodule

FILE: design/pba_alu.sv
module pba_alu (
   input  pba_pkg::pba_alu_req_type alu_req,
   output pba_pkg::pba_alu_rsp_type alu_rsp
);

   logic [pba_pkg::OCC_W:0] operand_b;
   logic [pba_pkg::OCC_W:0] sum;

   // one 33-bit adder: occ + bytes for admit, occ - bytes for release
   always_comb begin
      operand_b = {{(pba_pkg::OCC_W + 1 - pba_pkg::BYTES_W){1'b0}}, alu_req.bytes};
      if (alu_req.sub) begin
         operand_b = ~operand_b;
      end
      sum = {1'b0, alu_req.occ} + operand_b + {{pba_pkg::OCC_W{1'b0}}, alu_req.sub};
      alu_rsp.result = sum[pba_pkg::OCC_W-1:0];
      if (alu_req.sub) begin
         alu_rsp.ok = !sum[pba_pkg::OCC_W];
      end else begin
         alu_rsp.ok = (sum <= {1'b0, alu_req.limit});
      end
   end

endmodule

FILE: design/pba_seq.sv
module pba_seq (
   input  logic                                 clock,
   input  logic                                 reset,
   input  pba_pkg::pba_cfg_type                 cfg,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [pba_pkg::REQ_DATA_W-1:0]       req_tdata,
   input  logic                                 req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [pba_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   output logic [pba_pkg::STATUS_W-1:0]         rsp_tuser,
   output pba_pkg::pba_alu_req_type             alu_req,
   input  pba_pkg::pba_alu_rsp_type             alu_rsp
);

   pba_pkg::pba_state_type                                state_ff, state_in;
   pba_pkg::pba_op_type                                   op_ff, op_in;
   logic [pba_pkg::ID_W-1:0]                              bid_ff, bid_in;
   logic [pba_pkg::ID_W-1:0]                              rel_ff, rel_in;
   logic [pba_pkg::BYTES_W-1:0]                           bytes_ff, bytes_in;
   logic [pba_pkg::PART_W-1:0]                            idx_ff, idx_in;
   logic [pba_pkg::COUNT_W-1:0]                           cnt_ff, cnt_in;
   logic [pba_pkg::LIMIT_REGS-1:0][pba_pkg::OCC_W-1:0]    occ_ff, occ_in;
   pba_pkg::pba_status_type                               status_ff, status_in;
   logic [pba_pkg::PART_W-1:0]                            part_ff, part_in;
   logic [pba_pkg::OCC_W-1:0]                             res_occ_ff, res_occ_in;
   logic [pba_pkg::OCC_W-1:0]                             res_lim_ff, res_lim_in;
   logic                                                  rsp_valid_ff, rsp_valid_in;
   pba_pkg::pba_status_type                               rsp_status_ff, rsp_status_in;
   logic [pba_pkg::PART_W-1:0]                            rsp_part_ff, rsp_part_in;
   logic [pba_pkg::OCC_W-1:0]                             rsp_occ_ff, rsp_occ_in;
   logic [pba_pkg::OCC_W-1:0]                             rsp_lim_ff, rsp_lim_in;

   logic [pba_pkg::SLOT_W-1:0]   slot;
   logic [pba_pkg::COUNT_W-1:0]  cnt_raw;
   logic [pba_pkg::PART_W-1:0]   probe_part;
   logic                         probe_valid;
   logic                         last_choice;

   assign slot        = pba_pkg::map_slot(cfg.map, bid_ff[pba_pkg::PART_W-1:0]);
   assign cnt_raw     = slot[pba_pkg::COUNT_W-1:0];
   assign probe_part  = (op_ff == pba_pkg::OP_ENQUEUE) ? pba_pkg::pref_part(slot, idx_ff)
                                                       : rel_ff[pba_pkg::PART_W-1:0];
   assign probe_valid = ({1'b0, probe_part} < cfg.active);
   assign last_choice = (({1'b0, idx_ff} + 3'd1) == cnt_ff);

   assign alu_req.occ   = occ_ff[probe_part];
   assign alu_req.limit = cfg.limit[probe_part];
   assign alu_req.bytes = bytes_ff;
   assign alu_req.sub   = (op_ff == pba_pkg::OP_DEQUEUE);

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      bid_in        = bid_ff;
      rel_in        = rel_ff;
      bytes_in      = bytes_ff;
      idx_in        = idx_ff;
      cnt_in        = cnt_ff;
      occ_in        = occ_ff;
      status_in     = status_ff;
      part_in       = part_ff;
      res_occ_in    = res_occ_ff;
      res_lim_in    = res_lim_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_part_in   = rsp_part_ff;
      rsp_occ_in    = rsp_occ_ff;
      rsp_lim_in    = rsp_lim_ff;

      unique case (state_ff)
         pba_pkg::SEQ_IDLE: begin
            if (req_tvalid) begin
               op_in    = pba_pkg::pba_op_type'(req_tuser);
               bid_in   = req_tdata[7:0];
               rel_in   = req_tdata[15:8];
               bytes_in = req_tdata[31:16];
               state_in = pba_pkg::SEQ_DECODE;
            end
         end
         pba_pkg::SEQ_DECODE: begin
            status_in  = pba_pkg::ST_OK;
            part_in    = '0;
            res_occ_in = '0;
            res_lim_in = '0;
            idx_in     = '0;
            cnt_in     = (cnt_raw > pba_pkg::COUNT_W'(pba_pkg::CHOICE_MAX))
                         ? pba_pkg::COUNT_W'(pba_pkg::CHOICE_MAX) : cnt_raw;
            if (op_ff == pba_pkg::OP_ENQUEUE) begin
               if (bid_ff >= pba_pkg::ID_W'(pba_pkg::BID_MAX) || cnt_raw == '0) begin
                  status_in = pba_pkg::ST_BAD_BUFFER;
                  state_in  = pba_pkg::SEQ_FINISH;
               end else begin
                  state_in = pba_pkg::SEQ_PROBE;
               end
            end else begin
               if (rel_ff >= {{(pba_pkg::ID_W - pba_pkg::COUNT_W){1'b0}}, cfg.active}) begin
                  status_in = pba_pkg::ST_BAD_PARTITION;
                  state_in  = pba_pkg::SEQ_FINISH;
               end else begin
                  state_in = pba_pkg::SEQ_PROBE;
               end
            end
         end
         pba_pkg::SEQ_PROBE: begin
            if (op_ff == pba_pkg::OP_ENQUEUE) begin
               // one preference per cycle through the shared adder
               if (probe_valid && alu_rsp.ok) begin
                  occ_in[probe_part] = alu_rsp.result;
                  status_in          = pba_pkg::ST_OK;
                  part_in            = probe_part;
                  res_occ_in         = alu_rsp.result;
                  res_lim_in         = cfg.limit[probe_part];
                  state_in           = pba_pkg::SEQ_FINISH;
               end else if (last_choice) begin
                  status_in = pba_pkg::ST_DROP;
                  state_in  = pba_pkg::SEQ_FINISH;
               end else begin
                  idx_in = idx_ff + 2'd1;
               end
            end else begin
               part_in    = probe_part;
               res_lim_in = cfg.limit[probe_part];
               if (alu_rsp.ok) begin
                  occ_in[probe_part] = alu_rsp.result;
                  status_in          = pba_pkg::ST_OK;
                  res_occ_in         = alu_rsp.result;
               end else begin
                  status_in  = pba_pkg::ST_UNDERFLOW;
                  res_occ_in = occ_ff[probe_part];
               end
               state_in = pba_pkg::SEQ_FINISH;
            end
         end
         pba_pkg::SEQ_FINISH: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_part_in   = part_ff;
               rsp_occ_in    = res_occ_ff;
               rsp_lim_in    = res_lim_ff;
               state_in      = pba_pkg::SEQ_IDLE;
            end
         end
         default: begin
            state_in = pba_pkg::SEQ_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pba_pkg::SEQ_IDLE;
         rsp_valid_ff <= 1'b0;
         occ_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         occ_ff       <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      bid_ff        <= bid_in;
      rel_ff        <= rel_in;
      bytes_ff      <= bytes_in;
      idx_ff        <= idx_in;
      cnt_ff        <= cnt_in;
      status_ff     <= status_in;
      part_ff       <= part_in;
      res_occ_ff    <= res_occ_in;
      res_lim_ff    <= res_lim_in;
      rsp_status_ff <= rsp_status_in;
      rsp_part_ff   <= rsp_part_in;
      rsp_occ_ff    <= rsp_occ_in;
      rsp_lim_ff    <= rsp_lim_in;
   end

   assign req_tready = (state_ff == pba_pkg::SEQ_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {{pba_pkg::RSP_PAD_W{1'b0}}, rsp_lim_ff, rsp_occ_ff, rsp_part_ff};

endmodule

FILE: tb/sv/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pba_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 3'd7;
   localparam int DRAIN_CYCLES = 12;
   localparam int RANDOM_PHASES = 7;
   localparam int PHASE_REQUESTS = 175;

   typedef struct packed {
      pba_op_type         op;
      logic [ID_W-1:0]    bid;
      logic [ID_W-1:0]    rel;
      logic [BYTES_W-1:0] bytes;
   } pkt_request_type;

   typedef struct packed {
      pba_status_type     status;
      logic [PART_W-1:0]  part;
      logic [OCC_W-1:0]   occ;
      logic [OCC_W-1:0]   lim;
   } admit_outcome_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [STATUS_W-1:0]   rsp_tuser;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // shadow copy of the block's configuration and byte counts
   logic [COUNT_W-1:0] part_count;
   logic [OCC_W-1:0]   pool_cap [LIMIT_REGS];
   logic [MAP_W-1:0]   buffer_table;
   logic [OCC_W-1:0]   pool_fill [NUM_PARTITIONS];

   pkt_request_type   request_q[$];
   admit_outcome_type outcome_q[$];
   pkt_request_type   req_now = '0;
   bit                req_busy = 1'b0;
   int                req_gap = 0;
   bit                req_steady = 1'b0;
   int                rsp_gap = 0;
   int                rsp_hold = 0;
   bit                rsp_steady = 1'b0;

   int mismatch_count = 0;
   int accepted_count = 0;
   int settings_count = 0;
   int status_seen [5];

   partitioned_buffer_admission_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #3_000_000;
      $display("partitioned_buffer_admission_unit: mismatch");
      $finish;
   end

   task automatic report_mismatch(string what, longint got, longint want);
      mismatch_count++;
      if (mismatch_count <= 40)
         $display("error at %0t ns: %s got %0h expected %0h", $realtime, what, got, want);
   endtask

   // works out the outcome of one accepted request and updates the shadow counts
   function automatic void admit_or_release(pkt_request_type r);
      admit_outcome_type o;
      int                active;
      int                choices;
      logic [SLOT_W-1:0] slot;
      logic [PART_W-1:0] p;
      logic [OCC_W:0]    sum;
      o = '{status: ST_DROP, part: '0, occ: '0, lim: '0};
      active = (part_count > ACTIVE_MAX) ? ACTIVE_MAX : int'(part_count);
      if (r.op == OP_ENQUEUE) begin
         if (int'(r.bid) >= BID_MAX) begin
            o.status = ST_BAD_BUFFER;
         end else begin
            slot = buffer_table[int'(r.bid) * SLOT_W +: SLOT_W];
            choices = int'(slot[COUNT_W-1:0]);
            if (choices == 0) begin
               o.status = ST_BAD_BUFFER;
            end else begin
               if (choices > CHOICE_MAX) choices = CHOICE_MAX;
               for (int i = 0; i < choices; i++) begin
                  p = slot[COUNT_W + PART_W * i +: PART_W];
                  if (int'(p) < active) begin
                     sum = {1'b0, pool_fill[p]} + r.bytes;
                     if (sum <= {1'b0, pool_cap[p]}) begin
                        pool_fill[p] = sum[OCC_W-1:0];
                        o = '{status: ST_OK, part: p, occ: pool_fill[p], lim: pool_cap[p]};
                        break;
                     end
                  end
               end
            end
         end
      end else if (int'(r.rel) >= active) begin
         o.status = ST_BAD_PARTITION;
      end else begin
         p = r.rel[PART_W-1:0];
         if (pool_fill[p] < r.bytes) begin
            o = '{status: ST_UNDERFLOW, part: p, occ: pool_fill[p], lim: pool_cap[p]};
         end else begin
            pool_fill[p] = pool_fill[p] - r.bytes;
            o = '{status: ST_OK, part: p, occ: pool_fill[p], lim: pool_cap[p]};
         end
      end
      status_seen[int'(o.status)]++;
      accepted_count++;
      outcome_q.insert(outcome_q.size(), o);
   endfunction

   // request driver: holds valid until accepted, idles at random between requests
   always @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         admit_or_release(req_now);
         req_busy = 1'b0;
      end
      if (!req_busy) begin
         if (req_gap > 0) begin
            req_gap--;
         end else if (request_q.size() > 0) begin
            if (!req_steady && $urandom_range(0, 99) < 7) begin
               req_gap = $urandom_range(0, 4);
            end else begin
               req_now = request_q.pop_front();
               req_busy = 1'b1;
            end
         end
      end
      req_tvalid <= req_busy;
      req_tdata  <= {req_now.bytes, req_now.rel, req_now.bid};
      req_tuser  <= req_now.op;
   end

   // result side ready, with random stalls and an occasional long hold-off
   always @(posedge clock) begin
      if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_tready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_tready <= 1'b0;
      end else if (!rsp_steady && $urandom_range(0, 99) < 7) begin
         rsp_gap = $urandom_range(0, 5);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin : rsp_monitor
      admit_outcome_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (outcome_q.size() == 0) begin
            report_mismatch("result with nothing pending, status", rsp_tuser, 0);
         end else begin
            want = outcome_q.pop_front();
            if (rsp_tuser !== want.status)
               report_mismatch("status", rsp_tuser, want.status);
            if (rsp_tdata[PART_W-1:0] !== want.part)
               report_mismatch("chosen_partition", rsp_tdata[PART_W-1:0], want.part);
            if (rsp_tdata[PART_W +: OCC_W] !== want.occ)
               report_mismatch("occupancy_after", rsp_tdata[PART_W +: OCC_W], want.occ);
            if (rsp_tdata[PART_W + OCC_W +: OCC_W] !== want.lim)
               report_mismatch("partition_limit", rsp_tdata[PART_W + OCC_W +: OCC_W],
                               want.lim);
            if (rsp_tdata[RSP_DATA_W-1 -: RSP_PAD_W] !== '0)
               report_mismatch("pad bits", rsp_tdata[RSP_DATA_W-1 -: RSP_PAD_W], 0);
         end
      end
   end

   task automatic send_request(pba_op_type op, logic [ID_W-1:0] bid, logic [ID_W-1:0] rel,
                               logic [BYTES_W-1:0] bytes);
      pkt_request_type r;
      r = '{op: op, bid: bid, rel: rel, bytes: bytes};
      request_q.insert(request_q.size(), r);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_NUM_PARTITIONS: part_count = value[COUNT_W-1:0];
         CSR_LIMIT_P0:       pool_cap[0] = value[OCC_W-1:0];
         CSR_LIMIT_P1:       pool_cap[1] = value[OCC_W-1:0];
         CSR_LIMIT_P2:       pool_cap[2] = value[OCC_W-1:0];
         CSR_LIMIT_P3:       pool_cap[3] = value[OCC_W-1:0];
         CSR_BUFFER_MAP:     buffer_table = value[MAP_W-1:0];
         default: ;
      endcase
      settings_count++;
   endtask

   // all requests sent and answered, then let the pipeline settle
   task automatic wait_idle();
      do @(posedge clock); while (request_q.size() > 0 || req_busy || outcome_q.size() > 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [SLOT_W-1:0] make_slot(int count, int p0, int p1, int p2, int p3);
      return {2'(p3), 2'(p2), 2'(p1), 2'(p0), 3'(count)};
   endfunction

   task automatic test_reset_values();
      // count zero everywhere, limits zero
      send_request(OP_ENQUEUE, 8'd0, 8'd0, 16'd10);
      send_request(OP_DEQUEUE, 8'd3, 8'd0, 16'd0);
      send_request(OP_DEQUEUE, 8'd0, 8'd1, 16'd1);
      wait_idle();
   endtask

   task automatic test_directed();
      write_csr(CSR_NUM_PARTITIONS, 44'd4);
      write_csr(CSR_LIMIT_P0, 44'd100);
      write_csr(CSR_LIMIT_P1, {12'hABC, 32'hFFFF_FFFF});
      write_csr(CSR_LIMIT_P2, 44'd1000);
      write_csr(CSR_LIMIT_P3, 44'd0);
      write_csr(CSR_BUFFER_MAP, {make_slot(4, 2, 2, 1, 0), make_slot(1, 3, 0, 0, 0),
                                 make_slot(7, 3, 2, 0, 1), make_slot(2, 0, 1, 0, 0)});
      send_request(OP_ENQUEUE, 8'd0, 8'hFF, 16'd60);
      send_request(OP_ENQUEUE, 8'd0, 8'd0, 16'd40);      // fills p0 exactly
      send_request(OP_ENQUEUE, 8'd0, 8'd0, 16'd1);       // spills to p1
      send_request(OP_ENQUEUE, 8'd0, 8'h5A, 16'hFFFF);
      send_request(OP_ENQUEUE, 8'd2, 8'd0, 16'd0);       // zero bytes into zero limit
      send_request(OP_ENQUEUE, 8'd2, 8'd0, 16'd1);
      send_request(OP_ENQUEUE, 8'd1, 8'd0, 16'hFFFF);    // count above four
      send_request(OP_ENQUEUE, 8'd3, 8'd0, 16'd999);
      send_request(OP_ENQUEUE, 8'd3, 8'd0, 16'd2);
      send_request(OP_DEQUEUE, 8'hFF, 8'd0, 16'd100);
      send_request(OP_DEQUEUE, 8'd0, 8'd0, 16'd1);
      send_request(OP_DEQUEUE, 8'd0, 8'd3, 16'd0);
      send_request(OP_ENQUEUE, 8'd4, 8'd0, 16'd1);
      send_request(OP_ENQUEUE, 8'hFF, 8'd0, 16'd1);
      send_request(OP_DEQUEUE, 8'd0, 8'd4, 16'd1);
      send_request(OP_DEQUEUE, 8'd0, 8'hFF, 16'd1);
      send_request(OP_ENQUEUE, 8'd0, 8'd0, 16'd50);
      wait_idle();
      // limit below the current count
      write_csr(CSR_LIMIT_P0, {12'hFFF, 32'd10});
      send_request(OP_ENQUEUE, 8'd0, 8'd0, 16'd5);
      send_request(OP_DEQUEUE, 8'd0, 8'd0, 16'd50);
      wait_idle();
      write_csr(CSR_NUM_PARTITIONS, 44'd2);
      send_request(OP_ENQUEUE, 8'd1, 8'd0, 16'd10);
      send_request(OP_ENQUEUE, 8'd3, 8'd0, 16'd1);
      send_request(OP_DEQUEUE, 8'd0, 8'd2, 16'd0);
      wait_idle();
      write_csr(CSR_NUM_PARTITIONS, 44'd0);
      send_request(OP_ENQUEUE, 8'd0, 8'd0, 16'd0);
      send_request(OP_DEQUEUE, 8'd0, 8'd0, 16'd0);
      wait_idle();
      write_csr(CSR_NUM_PARTITIONS, {41'h155_5555_5555, 3'd7});
      write_csr(CSR_SPARE_A, '1);
      write_csr(CSR_SPARE_B, 44'h123_4567_89AB);
      send_request(OP_DEQUEUE, 8'd0, 8'd3, 16'd0);
      wait_idle();
   endtask

   task automatic randomize_settings();
      logic [MAP_W-1:0] map;
      int unsigned      pick;
      if ($urandom_range(0, 9) == 0) write_csr(CSR_NUM_PARTITIONS, 44'($urandom_range(0, 7)));
      else write_csr(CSR_NUM_PARTITIONS, 44'($urandom_range(1, 4)));
      for (int p = 0; p < LIMIT_REGS; p++) begin
         pick = $urandom_range(0, 99);
         write_csr(CSR_LIMIT_P0 + CSR_IDX_W'(p),
                   {12'($urandom), (pick < 15) ? 32'd0 :
                                   (pick < 25) ? 32'hFFFF_FFFF :
                                                 32'($urandom_range(0, 400000))});
      end
      for (int b = 0; b < MAP_SLOTS; b++)
         map[b * SLOT_W +: SLOT_W] = make_slot(($urandom_range(0, 9) < 8) ?
                                                  $urandom_range(1, 4) : $urandom_range(0, 7),
                                               $urandom_range(0, 3), $urandom_range(0, 3),
                                               $urandom_range(0, 3), $urandom_range(0, 3));
      write_csr(CSR_BUFFER_MAP, map);
   endtask

   task automatic random_request();
      logic [BYTES_W-1:0] bytes;
      int unsigned        pick;
      pick = $urandom_range(0, 99);
      bytes = (pick < 40) ? 16'($urandom) :
              (pick < 85) ? 16'($urandom_range(0, 3000)) :
              (pick < 90) ? 16'd0 : (pick < 95) ? 16'hFFFF : 16'd1;
      send_request(($urandom_range(0, 99) < 55) ? OP_ENQUEUE : OP_DEQUEUE,
                   ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 3)) : 8'($urandom),
                   ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 3)) : 8'($urandom),
                   bytes);
   endtask

   task automatic test_random_traffic();
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         // first phase runs without any idle cycles on either side
         req_steady = (ph == 0);
         rsp_steady = (ph == 0);
         randomize_settings();
         repeat (PHASE_REQUESTS) random_request();
         wait_idle();
      end
      req_steady = 1'b0;
      rsp_steady = 1'b0;
   endtask

   task automatic test_backpressure();
      randomize_settings();
      rsp_hold = 300;
      repeat (40) random_request();
      wait_idle();
   endtask

   initial begin
      part_count   = NUM_PARTITIONS_RESET;
      buffer_table = '0;
      foreach (pool_cap[i]) pool_cap[i] = '0;
      foreach (pool_fill[i]) pool_fill[i] = '0;
      foreach (status_seen[i]) status_seen[i] = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_reset_values();
      test_directed();
      test_random_traffic();
      test_backpressure();
      wait_idle();
      $display("checked %0d requests across %0d register writes", accepted_count,
               settings_count);
      $display("outcomes: ok %0d, dropped %0d, bad buffer %0d, bad partition %0d, underflow %0d",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
      if (mismatch_count == 0 && outcome_q.size() == 0)
         $display("partitioned_buffer_admission_unit: match");
      else
         $display("partitioned_buffer_admission_unit: mismatch");
      $finish;
   end

endmodule
